// File: hdl/texel_format_packer_unit_macros.svh
// Assertion helpers shared by the texel packer RTL.
`ifndef TEXEL_FORMAT_PACKER_UNIT_MACROS_SVH
`define TEXEL_FORMAT_PACKER_UNIT_MACROS_SVH

// Clocked assertion that is off while reset is held.
`define TFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that only applies while a result is being offered.
`define TFP_ASSERT_OUT(label, cond, msg) \
  `TFP_ASSERT(label, out_valid_o |-> (cond), msg)

`endif

// File: hdl/texfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package texfp_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
  localparam logic [1:0] CFG_TEXEL_SIZE   = 2'd1;

  // Pixel format codes.
  localparam logic [1:0] FMT_RGBA = 2'd0;
  localparam logic [1:0] FMT_IA   = 2'd1;
  localparam logic [1:0] FMT_I    = 2'd2;

  // Texel size codes.
  localparam logic [1:0] SIZE_4  = 2'd0;
  localparam logic [1:0] SIZE_8  = 2'd1;
  localparam logic [1:0] SIZE_16 = 2'd2;
  localparam logic [1:0] SIZE_32 = 2'd3;

  localparam logic [1:0] PIXEL_FORMAT_RESET = FMT_RGBA;
  localparam logic [1:0] TEXEL_SIZE_RESET   = SIZE_16;

  // Divide-by-three of a sum below 768: (s * 683) >> 11 is exact there.
  localparam logic [9:0] LUM_RECIP = 10'd683;
  localparam int unsigned LUM_SHIFT = 11;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  intensity;
    logic        alpha_nz;
    logic [15:0] rgba16;
  } lane_t;

endpackage

`default_nettype wire

// File: hdl/texfp_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module texfp_lane (
  input  texfp_pkg::pixel_t pixel_i,
  output texfp_pkg::lane_t  lane_o
);
  import texfp_pkg::*;

  logic [9:0]  sum;
  logic [19:0] prod;

  assign sum  = {2'b00, pixel_i.red} + {2'b00, pixel_i.green} + {2'b00, pixel_i.blue};
  assign prod = sum * LUM_RECIP;

  assign lane_o.intensity = prod[LUM_SHIFT +: 8];
  assign lane_o.alpha_nz  = |pixel_i.alpha;
  assign lane_o.rgba16    = {pixel_i.red[7:3], pixel_i.green[7:3], pixel_i.blue[7:3],
                             lane_o.alpha_nz};

endmodule

`default_nettype wire

// File: hdl/texfp_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module texfp_merge (
  input  logic [1:0]        pixel_format_i,
  input  logic [1:0]        texel_size_i,
  input  texfp_pkg::pixel_t pix0_i,
  input  texfp_pkg::pixel_t pix1_i,
  input  texfp_pkg::lane_t  lane0_i,
  input  texfp_pkg::lane_t  lane1_i,
  output logic [63:0]       packed_o,
  output logic [3:0]        count_o
);
  import texfp_pkg::*;

  logic [7:0] i0;
  logic [7:0] i1;

  assign i0 = lane0_i.intensity;
  assign i1 = lane1_i.intensity;

  always_comb begin
    packed_o = '0;
    count_o  = 4'd0;
    unique case (pixel_format_i)
      FMT_RGBA: begin
        if (texel_size_i == SIZE_16) begin
          packed_o = {32'd0, lane0_i.rgba16, lane1_i.rgba16};
          count_o  = 4'd4;
        end else if (texel_size_i == SIZE_32) begin
          packed_o = {pix0_i, pix1_i};
          count_o  = 4'd8;
        end
      end
      FMT_IA: begin
        unique case (texel_size_i)
          SIZE_4: begin
            packed_o = {56'd0, i0[7:5], lane0_i.alpha_nz, i1[7:5], lane1_i.alpha_nz};
            count_o  = 4'd1;
          end
          SIZE_8: begin
            packed_o = {48'd0, i0[7:4], pix0_i.alpha[7:4], i1[7:4], pix1_i.alpha[7:4]};
            count_o  = 4'd2;
          end
          SIZE_16: begin
            packed_o = {32'd0, i0, pix0_i.alpha, i1, pix1_i.alpha};
            count_o  = 4'd4;
          end
          default: begin
            packed_o = '0;
            count_o  = 4'd0;
          end
        endcase
      end
      FMT_I: begin
        if (texel_size_i == SIZE_4) begin
          packed_o = {56'd0, i0[7:4], i1[7:4]};
          count_o  = 4'd1;
        end else if (texel_size_i == SIZE_8) begin
          packed_o = {48'd0, i0, i1};
          count_o  = 4'd2;
        end
      end
      default: begin
        packed_o = '0;
        count_o  = 4'd0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/texel_format_packer_unit.sv
// Both lanes and the merge sit before one output register, from which the result is offered.
// Throughput: one pixel pair per cycle while the output register is not stalled by the sink.
// The input is ready whenever the output register is empty or its result is taken this cycle.
// Reset clears the output valid flag and sets pixel_format to rgba and texel_size to 16 bits.
`timescale 1ns / 1ps
`default_nettype none
`include "texel_format_packer_unit_macros.svh"

module texel_format_packer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  first_red_i,
  input  logic [7:0]  first_green_i,
  input  logic [7:0]  first_blue_i,
  input  logic [7:0]  first_alpha_i,
  input  logic [7:0]  second_red_i,
  input  logic [7:0]  second_green_i,
  input  logic [7:0]  second_blue_i,
  input  logic [7:0]  second_alpha_i,
  input  logic        final_pair_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] packed_bytes_o,
  output logic [3:0]  byte_count_o,
  output logic        final_out_o
);
  import texfp_pkg::*;

  logic [1:0]  pixel_format_q;
  logic [1:0]  texel_size_q;
  logic        out_valid_q;
  logic [63:0] packed_q;
  logic [63:0] packed_d;
  logic [3:0]  count_q;
  logic [3:0]  count_d;
  logic        final_q;
  logic        in_fire;
  pixel_t      pix [2];
  lane_t       lane [2];
  logic        count_legal;
  logic        upper_bytes_zero;
  logic        size_wr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_format_q <= PIXEL_FORMAT_RESET;
      texel_size_q   <= TEXEL_SIZE_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_PIXEL_FORMAT) begin
        pixel_format_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_TEXEL_SIZE) begin
        texel_size_q <= cfg_data_i;
      end
    end
  end

  assign pix[0] = '{red: first_red_i, green: first_green_i, blue: first_blue_i,
                    alpha: first_alpha_i};
  assign pix[1] = '{red: second_red_i, green: second_green_i, blue: second_blue_i,
                    alpha: second_alpha_i};

  for (genvar g = 0; g < 2; g++) begin : g_lane
    texfp_lane u_lane (
      .pixel_i(pix[g]),
      .lane_o (lane[g])
    );
  end

  texfp_merge u_merge (
    .pixel_format_i(pixel_format_q),
    .texel_size_i  (texel_size_q),
    .pix0_i        (pix[0]),
    .pix1_i        (pix[1]),
    .lane0_i       (lane[0]),
    .lane1_i       (lane[1]),
    .packed_o      (packed_d),
    .count_o       (count_d)
  );

  // The output register refills in the same cycle its result leaves.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      packed_q <= packed_d;
      count_q  <= count_d;
      final_q  <= final_pair_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign packed_bytes_o = packed_q;
  assign byte_count_o   = count_q;
  assign final_out_o    = final_q;

  // Only the counts that a packing can give are legal, and bytes above the count read as zero.
  always_comb begin
    count_legal      = 1'b0;
    upper_bytes_zero = 1'b0;
    unique case (byte_count_o)
      4'd0: begin
        count_legal      = 1'b1;
        upper_bytes_zero = (packed_bytes_o == 64'd0);
      end
      4'd1: begin
        count_legal      = 1'b1;
        upper_bytes_zero = (packed_bytes_o[63:8] == 56'd0);
      end
      4'd2: begin
        count_legal      = 1'b1;
        upper_bytes_zero = (packed_bytes_o[63:16] == 48'd0);
      end
      4'd4: begin
        count_legal      = 1'b1;
        upper_bytes_zero = (packed_bytes_o[63:32] == 32'd0);
      end
      4'd8: begin
        count_legal      = 1'b1;
        upper_bytes_zero = 1'b1;
      end
      default: begin
        count_legal      = 1'b0;
        upper_bytes_zero = 1'b0;
      end
    endcase
  end

  assign size_wr = cfg_valid_i && cfg_ready_o && (cfg_index_i == CFG_TEXEL_SIZE);

  `TFP_ASSERT(a_accept_gives_result, in_fire |=> out_valid_o, "accepted request lost")
  `TFP_ASSERT_OUT(a_count_legal, count_legal, "illegal byte count")
  `TFP_ASSERT_OUT(a_unused_bytes_zero, upper_bytes_zero, "bytes above count not zero")
  `TFP_ASSERT(a_cfg_size_write, size_wr |=> texel_size_q == $past(cfg_data_i), "size write lost")

endmodule

`default_nettype wire
